>>> sv/ritd_pkg.sv
package ritd_pkg;

  localparam int MAX_BASE   = 16;
  localparam int VALUE_BITS = 32;

  localparam int RAD_W = 5;
  localparam int DIG_W = (MAX_BASE > 1) ? $clog2(MAX_BASE) : 1;
  localparam int CNT_W = $clog2(VALUE_BITS);
  localparam int ND_W  = $clog2(VALUE_BITS + 1);
  localparam int CFG_W = 64;

  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    REG_BASE_SIZE   = 2'd0,
    REG_DIGITS_LOW  = 2'd1,
    REG_DIGITS_HIGH = 2'd2
  } reg_idx_t;

endpackage

>>> sv/ritd_if.sv
interface ritd_in_if;
  import ritd_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface ritd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink (input valid, input symbol, input last, output ready);
endinterface

>>> sv/radix_integer_to_digits_top.sv
// Each digit comes from one pass of a bit-serial divider, one dividend bit per cycle, over
// all VALUE_BITS bits; the symbols then leave by the output register, held while not ready.
// The next request is taken as soon as the last symbol sits in the output register.
// After every configuration write the alphabet check holds off requests until it finishes.
// Reset (synchronous, active low) clears the config and control registers, leaving the alphabet invalid.
module radix_integer_to_digits_top (
  input  logic                         clk,
  input  logic                         rst_n,
  ritd_in_if.sink                      in_chan,
  ritd_out_if.source                   out_chan,
  input  logic                         cfg_we,
  input  ritd_pkg::reg_idx_t           cfg_index,
  input  logic [ritd_pkg::CFG_W-1:0]   cfg_wdata
);
  import ritd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  logic [RAD_W-1:0] base_size_r;
  logic [63:0]      digits_low_r;
  logic [63:0]      digits_high_r;
  logic [7:0]       alpha [2**DIG_W];

  logic             chk_busy_r;
  logic             base_ok_r;
  logic [DIG_W-1:0] chk_i_r;
  logic [DIG_W-1:0] chk_j_r;
  logic [DIG_W-1:0] chk_last;
  logic             chk_fail;

  state_t                  st_r;
  logic [VALUE_BITS-1:0]   quo_r;
  logic [DIG_W-1:0]        rem_r;
  logic [CNT_W-1:0]        bit_cnt_r;
  logic                    nz_r;
  logic                    sign_pend_r;
  logic [ND_W-1:0]         nd_r;
  logic [ND_W-1:0]         top_idx;
  logic [DIG_W-1:0]        stack_r [VALUE_BITS];
  logic [VALUE_BITS-1:0]   in_raw;
  logic [VALUE_BITS-1:0]   in_mag;
  logic [RAD_W:0]          div_sh;
  logic [RAD_W:0]          div_dif;
  logic                    qbit;
  logic [DIG_W-1:0]        rem_nxt;
  logic                    out_valid_r;
  logic [7:0]              out_symbol_r;
  logic                    out_last_r;
  logic                    out_load;
  logic                    in_accept;

  for (genvar k = 0; k < 2**DIG_W; k++) begin : g_alpha
    if (k < 8) begin : g_low
      assign alpha[k] = digits_low_r[8*k +: 8];
    end else begin : g_high
      assign alpha[k] = digits_high_r[8*(k-8) +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_size_r   <= '0;
      digits_low_r  <= '0;
      digits_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_SIZE:   base_size_r   <= cfg_wdata[RAD_W-1:0];
        REG_DIGITS_LOW:  digits_low_r  <= cfg_wdata;
        REG_DIGITS_HIGH: digits_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The alphabet is checked one pair of entries per cycle after each write.
  assign chk_last = base_size_r[DIG_W-1:0] - DIG_W'(1);
  assign chk_fail = (base_size_r < RAD_W'(2)) || (base_size_r > RAD_W'(MAX_BASE)) ||
                    (alpha[chk_i_r] == SYM_PLUS) || (alpha[chk_i_r] == SYM_MINUS) ||
                    ((chk_j_r != chk_i_r) && (alpha[chk_i_r] == alpha[chk_j_r]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_busy_r <= 1'b0;
      base_ok_r  <= 1'b0;
      chk_i_r    <= '0;
      chk_j_r    <= '0;
    end else if (cfg_we) begin
      chk_busy_r <= 1'b1;
      base_ok_r  <= 1'b0;
      chk_i_r    <= '0;
      chk_j_r    <= '0;
    end else if (chk_busy_r) begin
      if (chk_fail) begin
        chk_busy_r <= 1'b0;
      end else if (chk_j_r == chk_last) begin
        if (chk_i_r == chk_last) begin
          chk_busy_r <= 1'b0;
          base_ok_r  <= 1'b1;
        end else begin
          chk_i_r <= chk_i_r + DIG_W'(1);
          chk_j_r <= chk_i_r + DIG_W'(1);
        end
      end else begin
        chk_j_r <= chk_j_r + DIG_W'(1);
      end
    end
  end

  assign in_chan.ready = (st_r == ST_IDLE) && !chk_busy_r;
  assign in_accept     = in_chan.valid && in_chan.ready;
  assign in_raw        = in_chan.value;
  assign in_mag        = in_raw[VALUE_BITS-1] ? (~in_raw + VALUE_BITS'(1)) : in_raw;

  assign div_sh  = {(RAD_W - DIG_W)'(0), rem_r, quo_r[VALUE_BITS-1]};
  assign div_dif = div_sh - {1'b0, base_size_r};
  assign qbit    = div_sh >= {1'b0, base_size_r};
  assign rem_nxt = qbit ? div_dif[DIG_W-1:0] : div_sh[DIG_W-1:0];

  assign top_idx  = nd_r - ND_W'(1);
  assign out_load = (st_r == ST_EMIT) && (!out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      nd_r        <= '0;
      sign_pend_r <= 1'b0;
      bit_cnt_r   <= '0;
      nz_r        <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (in_accept && base_ok_r) begin
            st_r        <= ST_DIV;
            sign_pend_r <= in_raw[VALUE_BITS-1];
            quo_r       <= in_mag;
            rem_r       <= '0;
            bit_cnt_r   <= '0;
            nz_r        <= 1'b0;
            nd_r        <= '0;
          end
        end
        ST_DIV: begin
          quo_r <= {quo_r[VALUE_BITS-2:0], qbit};
          if (bit_cnt_r == CNT_W'(VALUE_BITS - 1)) begin
            stack_r[nd_r[CNT_W-1:0]] <= rem_nxt;
            nd_r      <= nd_r + ND_W'(1);
            bit_cnt_r <= '0;
            rem_r     <= '0;
            nz_r      <= 1'b0;
            if (!(nz_r || qbit)) begin
              st_r <= ST_EMIT;
            end
          end else begin
            bit_cnt_r <= bit_cnt_r + CNT_W'(1);
            rem_r     <= rem_nxt;
            nz_r      <= nz_r || qbit;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            if (sign_pend_r) begin
              out_symbol_r <= SYM_MINUS;
              out_last_r   <= 1'b0;
              sign_pend_r  <= 1'b0;
            end else begin
              out_symbol_r <= alpha[stack_r[top_idx[CNT_W-1:0]]];
              out_last_r   <= (nd_r == ND_W'(1));
              nd_r         <= top_idx;
              if (nd_r == ND_W'(1)) begin
                st_r <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.symbol = out_symbol_r;
  assign out_chan.last   = out_last_r;

endmodule
